// File: src/crdc_pkg.sv
// ----------------------------------------------------------------------------
// crdc_pkg
// Shared types and constants of the configuration ROM directory crawler:
// the result item layout, the queue push bundle and the result codes.
// ----------------------------------------------------------------------------
package crdc_pkg;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    localparam logic [1:0] CAUSE_READ     = 2'd0;
    localparam logic [1:0] CAUSE_ABSENT   = 2'd1;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd2;

    localparam logic [31:0] ROOT_KEY       = 32'hc000_0005;
    localparam logic [31:0] OFFSET_MASK    = 32'h00ff_ffff;
    localparam logic [3:0]  BUS_INFO_WORDS = 4'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  idx;
        logic [31:0] word;
        logic [8:0]  len;
        logic [3:0]  max_rec;
        logic        cmc;
        logic        irmc;
        logic [1:0]  cause;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t item0;
        result_t item1;
    } q_push_t;

endpackage

// File: src/config_rom_directory_crawler.sv
// ----------------------------------------------------------------------------
// config_rom_directory_crawler
// Walks an IEEE 1212 configuration ROM depth first from read responses and
// emits read requests, image words and a final status item.
// ----------------------------------------------------------------------------
// Results of an item enter the output queue at the edge that accepts it, but
// when an item ends a block and resumes a pending one from the stack memory,
// the request for that block is pushed from the registered memory read data.
// No new item is taken while that read is pending or while the output queue
// lacks room for two results. Reset clears the walk state and the output queue;
// the stack memory is not cleared and is only read where it was written.
module config_rom_directory_crawler #(
    parameter int ROM_WORDS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // response_ok, response_word, zero pad
    input  logic [0:0]  s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // quadlet_index, stored_word, image_length,
                                  // max_record, cycle_master_capable,
                                  // iso_resource_capable, fail_cause, zero pad
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast
);
    import crdc_pkg::*;

    localparam int CW = $clog2(ROM_WORDS + 1);
    localparam int AW = $clog2(ROM_WORDS);
    localparam int EW = CW + 17;
    localparam int TW = CW + 25;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_BUSINFO = 2'd1;
    localparam logic [1:0] PH_HEADER  = 2'd2;
    localparam logic [1:0] PH_ENTRY   = 2'd3;

    logic [AW:0]   stack_mem [ROM_WORDS];
    logic [AW:0]   rdata_reg;

    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] end_reg, end_next;
    logic          isdir_reg, isdir_next;
    logic [CW-1:0] longest_reg, longest_next;
    logic [5:0]    biw_reg, biw_next;
    logic          pend_reg, pend_next;

    logic          accept;
    logic          in_mode;
    logic          in_ok;
    logic [31:0]   in_word;
    logic          room;

    logic [31:0]   word_v;
    logic [EW-1:0] end_v;
    logic [TW-1:0] tgt_v;
    logic [CW-1:0] cur_inc;
    logic [CW-1:0] blk_end_v;
    logic [CW-1:0] sp_v;
    logic          go_next;
    logic          pushed;
    logic          push_en;
    logic [AW-1:0] push_addr;
    logic [AW:0]   push_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    result_t       r0, r1;
    logic          v0, v1;
    q_push_t       q_push;
    result_t       head;

    function automatic result_t make_req(input logic [CW-1:0] idx);
        result_t r;
        r      = '0;
        r.kind = KIND_REQ;
        r.idx  = 8'(idx);
        return r;
    endfunction

    function automatic result_t make_store(input logic [CW-1:0] idx,
                                           input logic [31:0] word);
        result_t r;
        r      = '0;
        r.kind = KIND_STORE;
        r.idx  = 8'(idx);
        r.word = word;
        return r;
    endfunction

    function automatic result_t make_done(input logic [CW-1:0] len,
                                          input logic [5:0] biw);
        result_t r;
        r         = '0;
        r.kind    = KIND_DONE;
        r.len     = 9'(len);
        r.max_rec = biw[3:0];
        r.cmc     = biw[4];
        r.irmc    = biw[5];
        return r;
    endfunction

    function automatic result_t make_fail(input logic [1:0] cause);
        result_t r;
        r       = '0;
        r.kind  = KIND_FAIL;
        r.cause = cause;
        return r;
    endfunction

    assign in_mode  = s_tuser[0];
    assign in_ok    = s_tdata[0];
    assign in_word  = s_tdata[32:1];
    assign s_tready = !pend_reg && room;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        phase_next   = phase_reg;
        sp_next      = sp_reg;
        cur_next     = cur_reg;
        end_next     = end_reg;
        isdir_next   = isdir_reg;
        longest_next = longest_reg;
        biw_next     = biw_reg;
        pend_next    = 1'b0;
        word_v       = in_word;
        end_v        = '0;
        tgt_v        = '0;
        cur_inc      = cur_reg + CW'(1);
        blk_end_v    = end_reg;
        sp_v         = sp_reg;
        go_next      = 1'b0;
        pushed       = 1'b0;
        push_en      = 1'b0;
        push_addr    = sp_reg[AW-1:0];
        push_data    = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        r0           = '0;
        r1           = '0;
        v0           = 1'b0;
        v1           = 1'b0;

        if (pend_reg) begin
            cur_next   = CW'(rdata_reg[AW-1:0]);
            isdir_next = rdata_reg[AW];
            r0         = make_req(CW'(rdata_reg[AW-1:0]));
            v0         = 1'b1;
        end else if (accept) begin
            if (!in_mode) begin
                sp_next      = '0;
                cur_next     = '0;
                end_next     = '0;
                isdir_next   = 1'b0;
                longest_next = CW'(BUS_INFO_WORDS);
                biw_next     = '0;
                phase_next   = PH_BUSINFO;
                r0           = make_req('0);
                v0           = 1'b1;
            end else if (phase_reg == PH_IDLE) begin
                v0 = 1'b0;
            end else if (!in_ok) begin
                phase_next = PH_IDLE;
                r0         = make_fail(CAUSE_READ);
                v0         = 1'b1;
            end else begin
                case (phase_reg)
                    PH_BUSINFO: begin
                        if (cur_reg == '0 && in_word == '0) begin
                            phase_next = PH_IDLE;
                            r0         = make_fail(CAUSE_ABSENT);
                            v0         = 1'b1;
                        end else begin
                            r0 = make_store(cur_reg, in_word);
                            v0 = 1'b1;
                            if (cur_reg == CW'(2)) begin
                                biw_next = {in_word[31], in_word[30], in_word[15:12]};
                            end
                            if (cur_inc >= CW'(BUS_INFO_WORDS)) begin
                                cur_next   = CW'(ROOT_KEY & OFFSET_MASK);
                                isdir_next = (ROOT_KEY[31:30] == 2'b11);
                                phase_next = PH_HEADER;
                            end else begin
                                cur_next = cur_inc;
                            end
                            r1 = make_req(cur_next);
                            v1 = 1'b1;
                        end
                    end
                    PH_HEADER: begin
                        end_v = EW'(cur_reg) + EW'(in_word[31:16]) + EW'(1);
                        if (end_v > EW'(ROM_WORDS)) begin
                            word_v = '0;
                            end_v  = EW'(cur_reg) + EW'(1);
                        end
                        blk_end_v = CW'(end_v);
                        end_next  = blk_end_v;
                        if (blk_end_v > longest_reg) begin
                            longest_next = blk_end_v;
                        end
                        go_next = 1'b1;
                    end
                    PH_ENTRY: begin
                        go_next = 1'b1;
                        if (isdir_reg && in_word[31]) begin
                            tgt_v = TW'(cur_reg) + TW'(in_word & OFFSET_MASK);
                            if (tgt_v >= TW'(ROM_WORDS)) begin
                                word_v = '0;
                            end else if (sp_reg >= CW'(ROM_WORDS)) begin
                                go_next    = 1'b0;
                                phase_next = PH_IDLE;
                                r0         = make_fail(CAUSE_OVERFLOW);
                                v0         = 1'b1;
                            end else begin
                                push_en   = 1'b1;
                                push_data = {in_word[30], tgt_v[AW-1:0]};
                                sp_v      = sp_reg + CW'(1);
                                pushed    = 1'b1;
                            end
                        end
                    end
                    default: begin
                        v0 = 1'b0;
                    end
                endcase

                if (go_next) begin
                    r0 = make_store(cur_reg, word_v);
                    v0 = 1'b1;
                    if (cur_reg == CW'(2)) begin
                        biw_next = {word_v[31], word_v[30], word_v[15:12]};
                    end
                    sp_next = sp_v;
                    if (cur_inc < blk_end_v) begin
                        phase_next = PH_ENTRY;
                        cur_next   = cur_inc;
                        r1         = make_req(cur_inc);
                        v1         = 1'b1;
                    end else if (sp_v != '0) begin
                        // An entry just pushed is the top of the stack and is taken without a memory read.
                        sp_next    = sp_v - CW'(1);
                        phase_next = PH_HEADER;
                        if (pushed) begin
                            cur_next   = CW'(tgt_v[AW-1:0]);
                            isdir_next = in_word[30];
                            r1         = make_req(CW'(tgt_v[AW-1:0]));
                            v1         = 1'b1;
                        end else begin
                            rd_en     = 1'b1;
                            rd_addr   = sp_next[AW-1:0];
                            pend_next = 1'b1;
                        end
                    end else begin
                        phase_next = PH_IDLE;
                        r1         = make_done(longest_next, biw_next);
                        v1         = 1'b1;
                    end
                end
            end
        end

        r0.last = !v1 && !pend_next;
        r1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sp_reg      <= '0;
            cur_reg     <= '0;
            end_reg     <= '0;
            isdir_reg   <= 1'b0;
            longest_reg <= '0;
            biw_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sp_reg      <= sp_next;
            cur_reg     <= cur_next;
            end_reg     <= end_next;
            isdir_reg   <= isdir_next;
            longest_reg <= longest_next;
            biw_reg     <= biw_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[push_addr] <= push_data;
        end
        if (rd_en) begin
            rdata_reg <= stack_mem[rd_addr];
        end
    end

    always_comb begin
        q_push.valid0 = v0;
        q_push.valid1 = v1;
        q_push.item0  = r0;
        q_push.item1  = r1;
    end

    crdc_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {7'b0, head.cause, head.irmc, head.cmc, head.max_rec,
                      head.len, head.word, head.idx};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// File: src/crdc_out_queue.sv
// ----------------------------------------------------------------------------
// crdc_out_queue
// Four-entry result queue. Takes up to two result items per cycle and
// hands them out one at a time on the master-side handshake.
// ----------------------------------------------------------------------------
module crdc_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  crdc_pkg::q_push_t push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output crdc_pkg::result_t out_item
);
    import crdc_pkg::*;

    result_t    slot_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;

    assign n_push    = {1'b0, push.valid0} + {1'b0, push.valid0 & push.valid1};
    assign out_valid = (count_reg != 3'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= 3'd2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + 3'(n_push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid0) begin
            slot_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.valid0 && push.valid1) begin
            slot_reg[wr_ptr_reg + 2'd1] <= push.item1;
        end
    end

endmodule

// File: src/crdc_checker.sv
// ----------------------------------------------------------------------------
// crdc_checker
// Port-level checks of the configuration ROM directory crawler, bound to
// the top level.
// ----------------------------------------------------------------------------
module crdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import crdc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("Stalled result item changed.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result item shown right after reset.");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_FAIL) |-> m_tlast)
        else $error("Final status item is not marked last.");

    a_store_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STORE |-> !m_tlast)
        else $error("Store item marked last.");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_FAIL)
            |-> m_tdata[39:0] == 40'd0)
        else $error("Status item carries an index or a word.");

endmodule

bind config_rom_directory_crawler crdc_checker u_crdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: tb/config_rom_directory_crawler_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// config_rom_directory_crawler_test
// Self-checking testbench for the configuration ROM directory crawler.
// Each walk is generated by answering the read requests that a built-in
// model of the crawler expects. Most walks finish; the rest end in read
// errors, absent nodes or restarts. Every result item is checked field by
// field against the model, with random idling on both streams.
// ----------------------------------------------------------------------------
module config_rom_directory_crawler_test;
    import crdc_pkg::*;

    localparam int ROM_SIZE       = 256;
    localparam int ROOT_INDEX     = ROOT_KEY & OFFSET_MASK;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CALM_FIRST     = 1200;
    localparam int CALM_LAST      = 2400;
    localparam int MAX_REPORTS    = 100;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_BUS_INFO,
        PHASE_HEADER,
        PHASE_ENTRY
    } crawl_phase_e;

    typedef enum int {
        WALK_NORMAL,
        WALK_WIDE,
        WALK_READ_ERROR,
        WALK_RESTART,
        WALK_ABSENT
    } walk_style_e;

    typedef struct packed {
        logic        mode;
        logic        ok;
        logic [31:0] word;
    } crawler_input_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // response_ok, response_word, zero pad
    logic [0:0]  s_tuser  = '0;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // quadlet_index, stored_word, image_length, max_record,
                                 // cycle_master_capable, iso_resource_capable,
                                 // fail_cause, zero pad
    logic [1:0]  m_tuser;        // kind
    logic        m_tlast;

    crawler_input_t crawler_inputs[$];
    result_t        crawl_results_due[$];

    logic [8:0]   dir_stack [ROM_SIZE];
    logic [8:0]   stack_depth = '0;
    crawl_phase_e phase       = PHASE_IDLE;
    logic [8:0]   cur_index   = '0;
    logic [8:0]   block_end   = '0;
    logic         block_dir   = 1'b0;
    logic [8:0]   extent      = '0;
    logic [31:0]  bus_info    = '0;

    int  walk_items      = 0;
    int  walks_started   = 0;
    int  walks_finished  = 0;
    int  walks_aborted   = 0;
    int  results_checked = 0;
    int  inputs_accepted = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    int  quiet_cycles    = 0;
    bit  s_took          = 1'b0;
    bit  wide_walk_done  = 1'b0;

    config_rom_directory_crawler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void emit(logic [1:0] kind, logic [8:0] index, logic [31:0] word,
                                 logic [8:0] length, logic [1:0] cause);
        result_t r;
        r = '0;
        r.kind = kind;
        if (kind == KIND_REQ || kind == KIND_STORE) begin
            r.idx = index[7:0];
        end
        if (kind == KIND_STORE) begin
            r.word = word;
        end
        if (kind == KIND_DONE) begin
            r.len     = length;
            r.max_rec = bus_info[15:12];
            r.cmc     = bus_info[30];
            r.irmc    = bus_info[31];
        end
        if (kind == KIND_FAIL) begin
            r.cause = cause;
        end
        crawl_results_due.push_back(r);
    endfunction

    function automatic void store_word(logic [8:0] index, logic [31:0] word);
        if (index == 9'd2) begin
            bus_info = word;
        end
        emit(KIND_STORE, index, word, '0, '0);
    endfunction

    function automatic void abort_walk(logic [1:0] cause);
        phase = PHASE_IDLE;
        emit(KIND_FAIL, '0, '0, '0, cause);
    endfunction

    function automatic void advance_in_block();
        logic [8:0] entry;
        cur_index = cur_index + 9'd1;
        if (cur_index < block_end) begin
            phase = PHASE_ENTRY;
            emit(KIND_REQ, cur_index, '0, '0, '0);
        end else if (stack_depth != 0) begin
            stack_depth = stack_depth - 9'd1;
            entry = dir_stack[stack_depth[7:0]];
            cur_index = {1'b0, entry[7:0]};
            block_dir = entry[8];
            phase = PHASE_HEADER;
            emit(KIND_REQ, cur_index, '0, '0, '0);
        end else begin
            phase = PHASE_IDLE;
            emit(KIND_DONE, '0, '0, extent, '0);
        end
    endfunction

    function automatic void predict_crawl_step(crawler_input_t it);
        int          due_before;
        logic [17:0] end_idx;
        logic [31:0] w;
        logic [31:0] target;
        bit          overflow;
        result_t     r;
        due_before = crawl_results_due.size();
        w = it.word;
        overflow = 1'b0;
        if (it.mode == 1'b0) begin
            stack_depth = '0;
            cur_index = '0;
            block_end = '0;
            block_dir = 1'b0;
            extent = 9'(BUS_INFO_WORDS);
            bus_info = '0;
            phase = PHASE_BUS_INFO;
            emit(KIND_REQ, '0, '0, '0, '0);
        end else if (phase == PHASE_IDLE) begin
        end else if (!it.ok) begin
            abort_walk(CAUSE_READ);
        end else if (phase == PHASE_BUS_INFO) begin
            if (cur_index == 0 && w == 0) begin
                abort_walk(CAUSE_ABSENT);
            end else begin
                store_word(cur_index, w);
                cur_index = cur_index + 9'd1;
                if (cur_index >= BUS_INFO_WORDS) begin
                    cur_index = 9'(ROOT_INDEX);
                    block_dir = (ROOT_KEY[31:30] == 2'b11);
                    phase = PHASE_HEADER;
                end
                emit(KIND_REQ, cur_index, '0, '0, '0);
            end
        end else if (phase == PHASE_HEADER) begin
            end_idx = 18'(cur_index) + 18'(w[31:16]) + 18'd1;
            if (end_idx > ROM_SIZE) begin
                w = '0;
                end_idx = 18'(cur_index) + 18'd1;
            end
            store_word(cur_index, w);
            if (end_idx > extent) begin
                extent = end_idx[8:0];
            end
            block_end = end_idx[8:0];
            advance_in_block();
        end else begin
            if (block_dir && w[31]) begin
                target = 32'(cur_index) + (w & OFFSET_MASK);
                if (target >= ROM_SIZE) begin
                    w = '0;
                end else if (stack_depth >= ROM_SIZE) begin
                    abort_walk(CAUSE_OVERFLOW);
                    overflow = 1'b1;
                end else begin
                    dir_stack[stack_depth[7:0]] = {w[30], target[7:0]};
                    stack_depth = stack_depth + 9'd1;
                end
            end
            if (!overflow) begin
                store_word(cur_index, w);
                advance_in_block();
            end
        end
        if (crawl_results_due.size() > due_before) begin
            r = crawl_results_due.pop_back();
            r.last = 1'b1;
            crawl_results_due.push_back(r);
        end
    endfunction

    function automatic void queue_item(logic mode, logic ok, logic [31:0] word);
        crawler_input_t it;
        it.mode = mode;
        it.ok   = ok;
        it.word = word;
        if (mode == 1'b0 || phase != PHASE_IDLE) begin
            walk_items++;
        end
        if (mode == 1'b0) begin
            walks_started++;
        end
        crawler_inputs.push_back(it);
        predict_crawl_step(it);
    endfunction

    function automatic logic [31:0] next_response(bit tame);
        logic [31:0] w;
        int          roll;
        w = $urandom;
        roll = $urandom_range(0, 11);
        case (phase)
            PHASE_BUS_INFO: begin
                if (cur_index == 0 && w == 0) begin
                    w = 32'h1;
                end
            end
            PHASE_HEADER: begin
                if (tame) begin
                    w[31:16] = '0;
                end else if (roll == 0) begin
                    w[31:16] = 16'($urandom_range(ROM_SIZE, 65535));
                end else begin
                    w[31:16] = 16'($urandom_range(0, 4));
                end
            end
            default: begin
                if (block_dir) begin
                    if (!tame && roll < 5) begin
                        w[31] = 1'b1;
                        w[23:0] = 24'($urandom_range(0, 24));
                    end else if (!tame && roll == 5) begin
                        w[31] = 1'b1;
                    end else begin
                        w[31] = 1'b0;
                    end
                end
            end
        endcase
        return w;
    endfunction

    task automatic run_walk(walk_style_e style);
        int          steps;
        int          budget;
        int          break_at;
        bit          root_open;
        logic [31:0] w;
        budget = $urandom_range(6, 50);
        break_at = $urandom_range(1, budget);
        steps = 0;
        root_open = 1'b0;
        queue_item(1'b0, 1'($urandom_range(0, 1)), $urandom);
        while (phase != PHASE_IDLE) begin
            steps++;
            w = $urandom;
            if (style == WALK_ABSENT) begin
                queue_item(1'b1, 1'b1, 32'h0);
            end else if (style == WALK_READ_ERROR && steps == break_at) begin
                queue_item(1'b1, 1'b0, w);
            end else if (style == WALK_RESTART && steps == break_at) begin
                style = WALK_NORMAL;
                steps = 0;
                queue_item(1'b0, 1'($urandom_range(0, 1)), w);
            end else if (style == WALK_WIDE && phase == PHASE_HEADER
                         && cur_index == ROOT_INDEX) begin
                w[31:16] = 16'd250;
                root_open = 1'b1;
                queue_item(1'b1, 1'b1, w);
            end else if (root_open) begin
                w[31] = 1'b1;
                w[23:0] = 24'd1;
                queue_item(1'b1, 1'b1, w);
                root_open = (phase == PHASE_ENTRY);
            end else begin
                queue_item(1'b1, 1'b1, next_response(style == WALK_WIDE || steps > budget));
            end
        end
    endtask

    task automatic queue_random_walk();
        int roll;
        roll = $urandom_range(0, 19);
        if (!wide_walk_done && walk_items > RANDOM_ITEMS / 3) begin
            wide_walk_done = 1'b1;
            run_walk(WALK_WIDE);
        end else if (roll < 2) begin
            run_walk(WALK_READ_ERROR);
        end else if (roll < 4) begin
            run_walk(WALK_RESTART);
        end else if (roll < 5) begin
            run_walk(WALK_ABSENT);
        end else begin
            if (roll == 19) begin
                repeat ($urandom_range(1, 3)) begin
                    queue_item(1'b1, 1'($urandom_range(0, 1)), $urandom);
                end
            end
            run_walk(WALK_NORMAL);
        end
    endtask

    task automatic wait_until_drained();
        while (crawler_inputs.size() != 0 || crawl_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    function automatic bit idle_roll();
        return (cycle_count < CALM_FIRST || cycle_count > CALM_LAST)
               && ($urandom_range(0, 99) < 36);
    endfunction

    always @(negedge aclk) begin : drive_inputs
        crawler_input_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_took) begin
                crawler_inputs.delete(0);
            end
            if (s_tvalid && !s_took) begin
            end else if (crawler_inputs.size() != 0 && !idle_roll()) begin
                it = crawler_inputs[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, it.word, it.ok};
                s_tuser  <= it.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !idle_roll();
        end
    end

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        cycle_count <= cycle_count + 1;
        s_took <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            inputs_accepted <= inputs_accepted + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = m_tuser;
            got.idx     = m_tdata[7:0];
            got.word    = m_tdata[39:8];
            got.len     = m_tdata[48:40];
            got.max_rec = m_tdata[52:49];
            got.cmc     = m_tdata[53];
            got.irmc    = m_tdata[54];
            got.cause   = m_tdata[56:55];
            got.last    = m_tlast;
            results_checked <= results_checked + 1;
            if (crawl_results_due.size() == 0) begin
                report_error($sformatf("result item of kind %0d with none expected",
                                       got.kind));
            end else begin
                want = crawl_results_due.pop_front();
                check_field("kind", 32'(got.kind), 32'(want.kind));
                check_field("quadlet_index", 32'(got.idx), 32'(want.idx));
                check_field("stored_word", got.word, want.word);
                check_field("image_length", 32'(got.len), 32'(want.len));
                check_field("max_record", 32'(got.max_rec), 32'(want.max_rec));
                check_field("cycle_master_capable", 32'(got.cmc), 32'(want.cmc));
                check_field("iso_resource_capable", 32'(got.irmc), 32'(want.irmc));
                check_field("fail_cause", 32'(got.cause), 32'(want.cause));
                check_field("is_last", 32'(got.last), 32'(want.last));
                if (want.kind == KIND_DONE) begin
                    walks_finished <= walks_finished + 1;
                end
                if (want.kind == KIND_FAIL) begin
                    walks_aborted <= walks_aborted + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_test
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Responses with no walk running are ignored.
        queue_item(1'b1, 1'b1, 32'hffff_ffff);
        queue_item(1'b1, 1'b0, 32'h0000_0000);
        // The node is absent when its first quadlet reads as zero.
        queue_item(1'b0, 1'b1, 32'hffff_ffff);
        queue_item(1'b1, 1'b1, 32'h0000_0000);
        // All-ones bus info and a root header that runs past the end of the ROM.
        queue_item(1'b0, 1'b0, 32'h0000_0000);
        repeat (BUS_INFO_WORDS) queue_item(1'b1, 1'b1, 32'hffff_ffff);
        queue_item(1'b1, 1'b1, 32'hffff_ffff);
        // A read error in the middle of the bus info.
        queue_item(1'b0, 1'b1, 32'h1234_5678);
        queue_item(1'b1, 1'b1, 32'h0404_abcd);
        queue_item(1'b1, 1'b0, 32'hffff_ffff);
        // A small root with a pointer past the ROM and a leaf of one word.
        queue_item(1'b0, 1'b1, 32'h0000_0000);
        queue_item(1'b1, 1'b1, 32'h0404_abcd);
        repeat (BUS_INFO_WORDS - 1) queue_item(1'b1, 1'b1, 32'h0000_0000);
        queue_item(1'b1, 1'b1, 32'h0002_0000);
        queue_item(1'b1, 1'b1, 32'hc0ff_ffff);
        queue_item(1'b1, 1'b1, 32'h8000_0001);
        queue_item(1'b1, 1'b1, 32'h0001_beef);
        queue_item(1'b1, 1'b1, 32'hffff_ffff);

        walk_items = 0;
        while (walk_items < RANDOM_ITEMS / 2) begin
            queue_random_walk();
        end
        wait_until_drained();
        while (walk_items < RANDOM_ITEMS) begin
            queue_random_walk();
        end
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Crawler run: %0d input items, %0d walks started, %0d finished, %0d aborted.",
                 inputs_accepted, walks_started, walks_finished, walks_aborted);
        $display("Checked %0d result items, including a root directory spanning the ROM.",
                 results_checked);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
src/crdc_pkg.sv
src/crdc_out_queue.sv
src/config_rom_directory_crawler.sv
src/crdc_checker.sv
tb/config_rom_directory_crawler_test.sv
